@@ hdl/rtbp_pkg.sv @@
`default_nettype none

package rtbp_pkg;

  // Kind of table entry on the input channel.
  typedef enum logic [1:0] {
    MODE_WRITE = 2'd0,
    MODE_WAIT  = 2'd1,
    MODE_END   = 2'd2
  } mode_e;

  // Kind of result on the output channel.
  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_WAIT = 2'd1,
    KIND_DONE = 2'd2
  } out_kind_e;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_OVR_COUNT = 3'd0,
    REG_OVR_0     = 3'd1,
    REG_OVR_1     = 3'd2,
    REG_OVR_2     = 3'd3,
    REG_OVR_3     = 3'd4
  } reg_idx_e;

  localparam int PAIR_REGS   = 4;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Command kinds passed from the front end to the packer.
  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_WAIT  = 2'd1,
    CMD_DONE  = 2'd2
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e   kind;
    logic        flush_first;  // pending message goes out before this command
    logic        start_new;    // write opens a new message
    logic [15:0] addr;
    logic [7:0]  data;
    logic [15:0] wait_ms;
  } cmd_t;

  // Queue status seen by the front end and the packer.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FLUSH,
    ST_WR_HI,
    ST_WR_LO,
    ST_WR_DATA,
    ST_EMIT
  } back_state_e;

endpackage

`default_nettype wire

@@ hdl/rtbp_front.sv @@
`default_nettype none

module rtbp_front #(
  parameter int BURST_BYTES   = 64,
  parameter int MAX_OVERRIDES = 4
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [2:0]          cfg_index_i,
  input  wire logic [23:0]         cfg_data_i,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [1:0]          mode_i,
  input  wire logic [15:0]         entry_addr_i,
  input  wire logic [15:0]         entry_val_i,
  input  wire rtbp_pkg::q_status_t q_status_i,
  output logic                     push_o,
  output rtbp_pkg::cmd_t           cmd_o
);
  import rtbp_pkg::*;

  localparam int CNT_W = $clog2(BURST_BYTES + 1);
  localparam int LIM   = (MAX_OVERRIDES < PAIR_REGS) ? MAX_OVERRIDES : PAIR_REGS;
  localparam logic [2:0] LIM3 = 3'(LIM);

  logic [2:0]       ovr_count_q;
  logic [23:0]      ovr_entry_q [PAIR_REGS];
  logic [CNT_W-1:0] fill_q, fill_d;
  logic [15:0]      prev_q, prev_d;

  logic [2:0]       lim_c;
  logic [7:0]       data_c;
  logic             accept;
  logic             break_c;
  logic [CNT_W-1:0] base_c;
  logic [CNT_W-1:0] new_fill_c;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !q_status_i.full;
  assign accept      = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovr_count_q <= '0;
      for (int i = 0; i < PAIR_REGS; i++) begin
        ovr_entry_q[i] <= '0;
      end
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_OVR_COUNT: ovr_count_q    <= cfg_data_i[2:0];
        REG_OVR_0:     ovr_entry_q[0] <= cfg_data_i;
        REG_OVR_1:     ovr_entry_q[1] <= cfg_data_i;
        REG_OVR_2:     ovr_entry_q[2] <= cfg_data_i;
        REG_OVR_3:     ovr_entry_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Override lookup: the lowest-numbered matching pair wins.
  always_comb begin
    lim_c  = (ovr_count_q > LIM3) ? LIM3 : ovr_count_q;
    data_c = entry_val_i[7:0];
    for (int i = PAIR_REGS - 1; i >= 0; i--) begin
      if ((3'(i) < lim_c) && (ovr_entry_q[i][23:8] == entry_addr_i)) begin
        data_c = ovr_entry_q[i][7:0];
      end
    end
  end

  // Classification against a mirror of the packer's fill level.
  always_comb begin
    break_c    = (fill_q != '0) &&
                 ((prev_q == 16'hFFFF) || (entry_addr_i != prev_q + 16'd1));
    base_c     = break_c ? '0 : fill_q;
    new_fill_c = (base_c == '0) ? CNT_W'(3) : base_c + CNT_W'(1);

    fill_d = fill_q;
    prev_d = prev_q;
    push_o = 1'b0;

    cmd_o.kind        = CMD_WRITE;
    cmd_o.flush_first = 1'b0;
    cmd_o.start_new   = 1'b0;
    cmd_o.addr        = entry_addr_i;
    cmd_o.data        = data_c;
    cmd_o.wait_ms     = entry_val_i;

    unique case (mode_i)
      MODE_WRITE: begin
        push_o            = accept;
        cmd_o.flush_first = break_c;
        cmd_o.start_new   = (base_c == '0);
        if (accept) begin
          prev_d = entry_addr_i;
          fill_d = (new_fill_c == CNT_W'(BURST_BYTES)) ? '0 : new_fill_c;
        end
      end
      MODE_WAIT, MODE_END: begin
        push_o            = accept;
        cmd_o.kind        = (mode_i == MODE_WAIT) ? CMD_WAIT : CMD_DONE;
        cmd_o.flush_first = (fill_q != '0);
        if (accept) begin
          fill_d = '0;
        end
      end
      default: ;  // unused entry kind is dropped
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      prev_q <= '0;
    end else begin
      fill_q <= fill_d;
      prev_q <= prev_d;
    end
  end

endmodule

`default_nettype wire

@@ hdl/rtbp_fifo.sv @@
`default_nettype none

module rtbp_fifo (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire rtbp_pkg::cmd_t      cmd_i,
  input  wire logic                pop_i,
  output rtbp_pkg::cmd_t           cmd_o,
  output rtbp_pkg::q_status_t      status_o
);
  import rtbp_pkg::*;

  cmd_t              slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPTR_W:0]   count_q;

  assign status_o.full  = (count_q == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign status_o.empty = (count_q == '0);
  assign cmd_o          = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + (QPTR_W + 1)'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - (QPTR_W + 1)'(1);
      end
    end
  end

endmodule

`default_nettype wire

@@ hdl/rtbp_back.sv @@
`default_nettype none

module rtbp_back #(
  parameter int BURST_BYTES = 64
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire rtbp_pkg::q_status_t q_status_i,
  input  wire rtbp_pkg::cmd_t      cmd_i,
  output logic                     pop_o,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [1:0]               out_kind_o,
  output logic [7:0]               out_byte_o,
  output logic [15:0]              wait_ms_o,
  output logic                     last_byte_o
);
  import rtbp_pkg::*;

  localparam int CNT_W = $clog2(BURST_BYTES + 1);
  localparam int IDX_W = $clog2(BURST_BYTES);

  back_state_e      state_q, state_d;
  cmd_t             cmd_q;
  logic             after_q, after_d;
  logic [CNT_W-1:0] fill_q, fill_d;
  logic [IDX_W-1:0] rd_idx_q, rd_idx_d;
  logic [7:0]       burst_mem_q [BURST_BYTES];

  logic             out_valid_q;
  logic [1:0]       out_kind_q;
  logic [7:0]       out_byte_q;
  logic [15:0]      wait_ms_q;
  logic             last_q;

  logic             slot_free;
  logic             wr_en;
  logic [7:0]       wr_byte;
  logic             ld_mem;
  logic             ld_evt;
  logic             rd_last;
  back_state_e      act_state;

  assign slot_free = !out_valid_q || out_ready_i;
  assign rd_last   = (CNT_W'(rd_idx_q) + CNT_W'(1)) == fill_q;

  // Where the command held in cmd_q goes once any earlier flush is done.
  always_comb begin
    unique case (cmd_q.kind)
      CMD_WRITE: act_state = cmd_q.start_new ? ST_WR_HI : ST_WR_DATA;
      default:   act_state = ST_EMIT;
    endcase
  end

  always_comb begin
    state_d  = state_q;
    after_d  = after_q;
    fill_d   = fill_q;
    rd_idx_d = rd_idx_q;
    pop_o    = 1'b0;
    wr_en    = 1'b0;
    wr_byte  = cmd_q.data;
    ld_mem   = 1'b0;
    ld_evt   = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (!q_status_i.empty) begin
          pop_o   = 1'b1;
          after_d = 1'b0;
          if (cmd_i.flush_first) begin
            state_d = ST_FLUSH;
          end else if (cmd_i.kind == CMD_WRITE) begin
            state_d = cmd_i.start_new ? ST_WR_HI : ST_WR_DATA;
          end else begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_FLUSH: begin
        if (slot_free) begin
          ld_mem = 1'b1;
          if (rd_last) begin
            fill_d   = '0;
            rd_idx_d = '0;
            state_d  = after_q ? ST_IDLE : act_state;
          end else begin
            rd_idx_d = rd_idx_q + IDX_W'(1);
          end
        end
      end
      ST_WR_HI: begin
        wr_en   = 1'b1;
        wr_byte = cmd_q.addr[15:8];
        fill_d  = fill_q + CNT_W'(1);
        state_d = ST_WR_LO;
      end
      ST_WR_LO: begin
        wr_en   = 1'b1;
        wr_byte = cmd_q.addr[7:0];
        fill_d  = fill_q + CNT_W'(1);
        state_d = ST_WR_DATA;
      end
      ST_WR_DATA: begin
        wr_en  = 1'b1;
        fill_d = fill_q + CNT_W'(1);
        if (fill_d == CNT_W'(BURST_BYTES)) begin
          after_d = 1'b1;
          state_d = ST_FLUSH;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          ld_evt  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      after_q     <= 1'b0;
      fill_q      <= '0;
      rd_idx_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      after_q  <= after_d;
      fill_q   <= fill_d;
      rd_idx_q <= rd_idx_d;
      if (ld_mem || ld_evt) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cmd_q <= cmd_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      burst_mem_q[fill_q[IDX_W-1:0]] <= wr_byte;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_mem) begin
      out_byte_q <= burst_mem_q[rd_idx_q];
      out_kind_q <= KIND_BYTE;
      wait_ms_q  <= '0;
      last_q     <= rd_last;
    end else if (ld_evt) begin
      out_byte_q <= '0;
      out_kind_q <= (cmd_q.kind == CMD_WAIT) ? KIND_WAIT : KIND_DONE;
      wait_ms_q  <= (cmd_q.kind == CMD_WAIT) ? cmd_q.wait_ms : 16'd0;
      last_q     <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_kind_o  = out_kind_q;
  assign out_byte_o  = out_byte_q;
  assign wait_ms_o   = wait_ms_q;
  assign last_byte_o = last_q;

endmodule

`default_nettype wire

@@ hdl/register_table_burst_packer_unit.sv @@
// Register-table burst packer.
// Table entries (write, wait or end) arrive on the in_* channel; results leave
// on the out_* channel as message bytes, wait requests or a finished marker.
// Configuration writes on the cfg_* channel set the override count (index 0)
// and the four override pairs (indexes 1 to 4); they are always taken.
// A front end accepts an item, applies overrides, decides whether the pending
// message must be flushed first, and pushes a command into a four-entry
// queue. It stalls only when that queue is full.
// The packer behind the queue takes a command in its idle state; it stores a
// write that opens a message through WR_HI, WR_LO and WR_DATA (address high
// byte, address low byte, data) and a continued write through WR_DATA alone.
// A flush sends one byte per cycle, while the receiver takes them, from the
// burst memory, whose single read port sets that rate. A wait or end result
// is loaded into the output register in the EMIT state.
// Results sit in an output register; when the receiver stalls, the packer
// holds its work and the queue fills, then the input stalls in turn.
// Reset empties the queue and the pending message and clears the overrides.
`default_nettype none

module register_table_burst_packer_unit #(
  parameter int BURST_BYTES   = 64,
  parameter int MAX_OVERRIDES = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [23:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  mode_i,
  input  wire logic [15:0] entry_addr_i,
  input  wire logic [15:0] entry_val_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       out_kind_o,
  output logic [7:0]       out_byte_o,
  output logic [15:0]      wait_ms_o,
  output logic             last_byte_o
);
  import rtbp_pkg::*;

  q_status_t q_status;
  cmd_t      push_cmd;
  cmd_t      head_cmd;
  logic      push;
  logic      pop;

  // The front end owns the override registers and classifies each item.
  rtbp_front #(
    .BURST_BYTES  (BURST_BYTES),
    .MAX_OVERRIDES(MAX_OVERRIDES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .mode_i      (mode_i),
    .entry_addr_i(entry_addr_i),
    .entry_val_i (entry_val_i),
    .q_status_i  (q_status),
    .push_o      (push),
    .cmd_o       (push_cmd)
  );

  // Command queue decoupling the front end from the packer.
  rtbp_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .pop_i   (pop),
    .cmd_o   (head_cmd),
    .status_o(q_status)
  );

  // The packer holds the burst memory and drives the result register.
  rtbp_back #(
    .BURST_BYTES(BURST_BYTES)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_status_i (q_status),
    .cmd_i      (head_cmd),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_kind_o (out_kind_o),
    .out_byte_o (out_byte_o),
    .wait_ms_o  (wait_ms_o),
    .last_byte_o(last_byte_o)
  );

endmodule

`default_nettype wire
